@@ rtl/icon_palette_to_argb_top_macros.svh @@
// Assertion macros shared by the icon palette checker.
`ifndef ICON_PALETTE_TO_ARGB_TOP_MACROS_SVH
`define ICON_PALETTE_TO_ARGB_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, idle while rst is high.
`define ICON_PAL_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, idle while rst is high.
`define ICON_PAL_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

@@ rtl/icon_pal_pkg.sv @@
// Shared types and constants for the icon palette to ARGB converter.
package icon_pal_pkg;

  typedef enum logic [1:0] {
    OP_PAL_WRITE = 2'd0,
    OP_INDEXED   = 2'd1,
    OP_DIRECT    = 2'd2
  } op_t;

  localparam logic DEPTH_4BPP = 1'b0;
  localparam logic DEPTH_8BPP = 1'b1;

  localparam int S_TDATA_W = 80;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 32;
  localparam int COLOR_W   = 24;
  localparam int PIXEL_W   = 32;
  localparam int INDEX_W   = 8;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

  // Per-lane control for one pixel.
  typedef struct packed {
    logic is_direct;
    logic masked;
    logic out_of_range;
  } lane_ctrl_t;

  // What the lanes hand to the merge stage for one request.
  typedef struct packed {
    logic [PIXEL_W-1:0] pix0;
    logic [PIXEL_W-1:0] pix1;
    logic               two;
    logic               frame_end;
  } merge_in_t;

endpackage

@@ rtl/icon_pal_mem.sv @@
// Palette store: one write port, two registered read ports.
module icon_pal_mem #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [$clog2(PALETTE_DEPTH)-1:0]    wr_addr,
  input  logic [icon_pal_pkg::COLOR_W-1:0]    wr_data,
  input  logic                                rd_en,
  input  logic [$clog2(PALETTE_DEPTH)-1:0]    rd_addr0,
  input  logic [$clog2(PALETTE_DEPTH)-1:0]    rd_addr1,
  output logic [icon_pal_pkg::COLOR_W-1:0]    rd_data0,
  output logic [icon_pal_pkg::COLOR_W-1:0]    rd_data1
);

  logic [icon_pal_pkg::COLOR_W-1:0] mem [PALETTE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data0 <= mem[rd_addr0];
      rd_data1 <= mem[rd_addr1];
    end
  end

endmodule

@@ rtl/icon_pal_lane.sv @@
// One pixel lane: pick source, set alpha, swap red and blue.
module icon_pal_lane (
  input  icon_pal_pkg::lane_ctrl_t             ctrl,
  input  logic [icon_pal_pkg::COLOR_W-1:0]     color,
  input  logic [icon_pal_pkg::PIXEL_W-1:0]     direct_pixel,
  output logic [icon_pal_pkg::PIXEL_W-1:0]     pixel
);

  logic [icon_pal_pkg::PIXEL_W-1:0] src;
  logic [icon_pal_pkg::COLOR_W-1:0] rgb;
  logic [7:0]                       alpha;

  always_comb begin
    rgb   = ctrl.out_of_range ? '0 : color;
    alpha = ctrl.masked ? icon_pal_pkg::ALPHA_CLEAR : icon_pal_pkg::ALPHA_OPAQUE;
    src   = ctrl.is_direct ? direct_pixel : {alpha, rgb};
    // byte 0 and byte 2 trade places
    pixel = {src[31:24], src[7:0], src[15:8], src[23:16]};
  end

endmodule

@@ rtl/icon_pal_merge.sv @@
// Merge stage: takes one or two lane pixels and emits them one per cycle while m_tready is high.
module icon_pal_merge (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  icon_pal_pkg::merge_in_t              in_data,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [icon_pal_pkg::M_TDATA_W-1:0]   m_tdata,
  output logic                                 m_tlast,
  output logic                                 m_tuser
);

  logic [1:0]                       cnt;
  logic [icon_pal_pkg::PIXEL_W-1:0] head;
  logic [icon_pal_pkg::PIXEL_W-1:0] tail;
  logic                             frame_end;
  logic                             load;
  logic                             out_fire;

  assign out_fire = m_tvalid && m_tready;
  assign in_ready = (cnt == 2'd0) || ((cnt == 2'd1) && m_tready);
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= in_data.two ? 2'd2 : 2'd1;
    end else if (out_fire) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      head      <= in_data.pix0;
      tail      <= in_data.pix1;
      frame_end <= in_data.frame_end;
    end else if (out_fire) begin
      head <= tail;
    end
  end

  assign m_tvalid = (cnt != 2'd0);
  assign m_tdata  = head;
  assign m_tlast  = (cnt == 2'd1);
  assign m_tuser  = (cnt == 2'd1) && frame_end;

endmodule

@@ rtl/icon_palette_to_argb_top.sv @@
// Top level of the icon palette to ARGB pixel converter.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------------
//  s_*     | in  | s_tvalid / s_tready  | s_tdata fields, s_tuser op, s_tlast end
//  m_*     | out | m_tvalid / m_tready  | m_tdata argb, m_tlast run end, m_tuser
//  cfg_*   | in  | cfg_valid/cfg_ready  | cfg_data = index_depth
//
//  A request passes the palette read register, then the merge register,
//  on its way out. The one-pixel output port holds a 4bpp request, with a
//  pixel per nibble, longer than an 8bpp or direct request; merge takes the
//  next request as the last pixel leaves. Palette writes produce nothing.
//  Reset clears the pipeline valids and sets index_depth to 8bpp; palette
//  contents stay undefined until written. A stalled output holds its result
//  and backs up into the input only once the lane stage is also full.
module icon_palette_to_argb_top #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // slave request: bits from low up: palette_slot[7:0], palette_color[31:8],
  // index_byte[39:32], mask_bits[41:40], direct_pixel[73:42], zero pad [79:74]
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [icon_pal_pkg::S_TDATA_W-1:0]   s_tdata,
  input  logic [icon_pal_pkg::S_TUSER_W-1:0]   s_tuser,   // op[1:0]
  input  logic                                 s_tlast,   // image_end
  // master result: argb_pixel[31:0]
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [icon_pal_pkg::M_TDATA_W-1:0]   m_tdata,
  output logic                                 m_tlast,   // run_last
  output logic                                 m_tuser,   // frame_last
  // configuration write
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_data   // index_depth
);

  localparam int AW = $clog2(PALETTE_DEPTH);

  // unpacked input fields
  logic [7:0]                        palette_slot;
  logic [icon_pal_pkg::COLOR_W-1:0]  palette_color;
  logic [icon_pal_pkg::INDEX_W-1:0]  index_byte;
  logic [1:0]                        mask_bits;
  logic [icon_pal_pkg::PIXEL_W-1:0]  direct_pixel;

  assign palette_slot  = s_tdata[7:0];
  assign palette_color = s_tdata[31:8];
  assign index_byte    = s_tdata[39:32];
  assign mask_bits     = s_tdata[41:40];
  assign direct_pixel  = s_tdata[73:42];

  logic index_depth;
  logic s_fire;
  logic is_write;
  logic is_indexed;
  logic is_direct;
  logic has_result;
  logic slot_ok;
  logic [icon_pal_pkg::INDEX_W-1:0] addr0;
  logic [icon_pal_pkg::INDEX_W-1:0] addr1;

  // lane stage registers
  logic                              a_valid;
  logic                              a_two;
  logic                              a_direct;
  logic                              a_mask0;
  logic                              a_mask1;
  logic                              a_oor0;
  logic                              a_end;
  logic [icon_pal_pkg::PIXEL_W-1:0]  a_direct_pixel;

  logic [icon_pal_pkg::COLOR_W-1:0]  color0;
  logic [icon_pal_pkg::COLOR_W-1:0]  color1;
  icon_pal_pkg::lane_ctrl_t          ctrl0;
  icon_pal_pkg::lane_ctrl_t          ctrl1;
  icon_pal_pkg::merge_in_t           mrg_in;
  logic                              mrg_ready;

  // configuration is always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      index_depth <= icon_pal_pkg::DEPTH_8BPP;
    end else if (cfg_valid && cfg_ready) begin
      index_depth <= cfg_data;
    end
  end

  // op decode
  always_comb begin
    is_write   = 1'b0;
    is_indexed = 1'b0;
    is_direct  = 1'b0;
    unique case (s_tuser)
      icon_pal_pkg::OP_PAL_WRITE: is_write   = 1'b1;
      icon_pal_pkg::OP_INDEXED:   is_indexed = 1'b1;
      icon_pal_pkg::OP_DIRECT:    is_direct  = 1'b1;
      default: ;  // unused op: drop
    endcase
  end

  assign has_result = is_indexed || is_direct;
  assign slot_ok    = (32'(palette_slot) < PALETTE_DEPTH);

  // 4bpp splits the byte into two nibble indices, high nibble first
  assign addr0 = (index_depth == icon_pal_pkg::DEPTH_4BPP) ?
                 {4'h0, index_byte[7:4]} : index_byte;
  assign addr1 = {4'h0, index_byte[3:0]};

  // accept while the lane stage is empty or draining into merge
  assign s_tready = !a_valid || mrg_ready;
  assign s_fire   = s_tvalid && s_tready;

  icon_pal_mem #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_mem (
    .clk      (clk),
    .wr_en    (s_fire && is_write && slot_ok),
    .wr_addr  (palette_slot[AW-1:0]),
    .wr_data  (palette_color),
    .rd_en    (s_fire),
    .rd_addr0 (addr0[AW-1:0]),
    .rd_addr1 (addr1[AW-1:0]),
    .rd_data0 (color0),
    .rd_data1 (color1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_fire) begin
      a_valid <= has_result;
    end else if (mrg_ready) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      a_two          <= is_indexed && (index_depth == icon_pal_pkg::DEPTH_4BPP);
      a_direct       <= is_direct;
      // 8bpp uses only mask bit 1
      a_mask0        <= mask_bits[1];
      a_mask1        <= mask_bits[0];
      a_oor0         <= (32'(addr0) >= PALETTE_DEPTH);
      a_end          <= s_tlast;
      a_direct_pixel <= direct_pixel;
    end
  end

  assign ctrl0 = '{is_direct: a_direct, masked: a_mask0, out_of_range: a_oor0};
  // nibble indices are below 16, so lane 1 assumes they fall inside the store
  assign ctrl1 = '{is_direct: 1'b0, masked: a_mask1, out_of_range: 1'b0};

  icon_pal_lane u_lane0 (
    .ctrl         (ctrl0),
    .color        (color0),
    .direct_pixel (a_direct_pixel),
    .pixel        (mrg_in.pix0)
  );

  icon_pal_lane u_lane1 (
    .ctrl         (ctrl1),
    .color        (color1),
    .direct_pixel (a_direct_pixel),
    .pixel        (mrg_in.pix1)
  );

  assign mrg_in.two       = a_two;
  assign mrg_in.frame_end = a_end;

  icon_pal_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .in_valid (a_valid),
    .in_ready (mrg_ready),
    .in_data  (mrg_in),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

@@ rtl/icon_pal_checker.sv @@
// Port-level assertions for the icon palette converter, bound to the top level.
`include "icon_palette_to_argb_top_macros.svh"

module icon_pal_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 m_tvalid,
  input  logic                                 m_tready,
  input  logic [icon_pal_pkg::M_TDATA_W-1:0]   m_tdata,
  input  logic                                 m_tlast,
  input  logic                                 m_tuser
);

  logic                                 out_stall;
  logic [icon_pal_pkg::M_TDATA_W+1:0]   out_word;
  logic                                 pair_head;
  logic                                 alpha_ok;

  assign out_stall = m_tvalid && !m_tready;
  assign out_word  = {m_tuser, m_tlast, m_tdata};
  assign pair_head = m_tvalid && m_tready && !m_tlast;
  assign alpha_ok  = (m_tdata[31:24] == icon_pal_pkg::ALPHA_CLEAR) ||
                     (m_tdata[31:24] == icon_pal_pkg::ALPHA_OPAQUE);

  // hold a stalled result
  `ICON_PAL_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(out_word), "stalled result changed")

  // frame end only on the last result of a request
  `ICON_PAL_ASSERT_NOW(a_frame_on_last, m_tvalid && m_tuser, m_tlast, "frame_last without run_last")

  // second pixel of a 4bpp pair follows at once
  `ICON_PAL_ASSERT_NEXT(a_pair_follows, pair_head, m_tvalid, "second pixel of pair missing")

  // first of a pair is a palette pixel, so alpha is clear or opaque
  `ICON_PAL_ASSERT_NOW(a_pair_alpha, m_tvalid && !m_tlast, alpha_ok, "bad alpha on first pixel")

endmodule

bind icon_palette_to_argb_top icon_pal_checker u_checker (.*);

@@ test/tb_icon_palette_to_argb_top.sv @@
// Self-checking testbench for the icon palette to ARGB pixel converter.
module tb_icon_palette_to_argb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         PAL_DEPTH       = 256;
  localparam int         CLK_HALF        = 6;
  localparam int         RESET_CYCLES    = 5;
  // Two register stages inside the block; the drain wait adds margin.
  localparam int         DRAIN_CYCLES    = 6;
  localparam int         HOLD_OFF_CYCLES = 200;
  localparam int         MAX_REPORTS     = 10;
  localparam longint     RUN_LIMIT_NS    = 64'd10_000_000;
  // The package leaves the fourth selector code unnamed; the block drops it.
  localparam logic [1:0] OP_RESERVED     = 2'd3;

  localparam int         COLOR_W         = icon_pal_pkg::COLOR_W;
  localparam int         INDEX_W         = icon_pal_pkg::INDEX_W;
  localparam int         PIXEL_W         = icon_pal_pkg::PIXEL_W;
  localparam int         S_TDATA_W       = icon_pal_pkg::S_TDATA_W;
  localparam int         S_TUSER_W       = icon_pal_pkg::S_TUSER_W;
  localparam int         M_TDATA_W       = icon_pal_pkg::M_TDATA_W;

  // One input request, field by field.
  typedef struct {
    logic [1:0]         op;
    logic [7:0]         slot;
    logic [COLOR_W-1:0] color;
    logic [INDEX_W-1:0] index_byte;
    logic [1:0]         mask;
    logic [PIXEL_W-1:0] direct;
    logic               image_end;
  } pix_req_t;

  // One output pixel as it should leave the block.
  typedef struct {
    logic [PIXEL_W-1:0] argb;
    logic               run_last;
    logic               frame_last;
  } argb_beat_t;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata   = '0;
  logic [S_TUSER_W-1:0] s_tuser   = '0;
  logic                 s_tlast   = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tlast;
  logic                 m_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic                 cfg_data  = 1'b0;

  // Shadow of the block: palette contents, which entries were written, pixel depth.
  logic [COLOR_W-1:0]   pal_mem   [PAL_DEPTH];
  bit                   pal_valid [PAL_DEPTH];
  logic                 depth_mode = icon_pal_pkg::DEPTH_8BPP;
  argb_beat_t           pending_pixels [$];

  int                   err_count       = 0;
  int                   items_sent      = 0;
  int                   sink_stall_left = 0;
  bit                   src_steady      = 1'b0;
  bit                   sink_steady     = 1'b0;
  bit                   hold_off_req    = 1'b0;

  icon_palette_to_argb_top #(
    .PALETTE_DEPTH(PAL_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // slot, color, index_byte, mask_bits, direct_pixel, pad
    .s_tuser  (s_tuser),   // op
    .s_tlast  (s_tlast),   // image_end
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // argb_pixel
    .m_tlast  (m_tlast),   // run_last
    .m_tuser  (m_tuser),   // frame_last
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)   // index_depth
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(RUN_LIMIT_NS);
    $display("tb_icon_palette_to_argb_top failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Pixel math
  // ---------------------------------------------------------------------------

  function automatic argb_beat_t beat(logic [PIXEL_W-1:0] argb, logic run_last,
                                      logic frame_last);
    argb_beat_t b;
    b.argb       = argb;
    b.run_last   = run_last;
    b.frame_last = frame_last;
    return b;
  endfunction

  // Look the index up, put red in the low byte and blue in byte 2, and set
  // alpha from the mask bit: set means transparent.
  function automatic logic [PIXEL_W-1:0] palette_argb(logic [INDEX_W-1:0] idx,
                                                      logic masked);
    logic [COLOR_W-1:0] c;
    c = (idx < PAL_DEPTH) ? pal_mem[idx] : '0;
    return {masked ? icon_pal_pkg::ALPHA_CLEAR : icon_pal_pkg::ALPHA_OPAQUE,
            c[7:0], c[15:8], c[23:16]};
  endfunction

  // Update the shadow state for one accepted request and queue its pixels.
  function automatic void predict_request(pix_req_t r);
    logic [PIXEL_W-1:0] p;
    case (r.op)
      icon_pal_pkg::OP_PAL_WRITE: begin
        // Slots past the store are dropped by the block.
        if (r.slot < PAL_DEPTH) begin
          pal_mem[r.slot]   = r.color;
          pal_valid[r.slot] = 1'b1;
        end
      end
      icon_pal_pkg::OP_INDEXED: begin
        if (depth_mode == icon_pal_pkg::DEPTH_4BPP) begin
          // High nibble leaves first and never closes the run or the frame.
          pending_pixels.push_back(beat(palette_argb({4'h0, r.index_byte[7:4]},
                                                     r.mask[1]), 1'b0, 1'b0));
          pending_pixels.push_back(beat(palette_argb({4'h0, r.index_byte[3:0]},
                                                     r.mask[0]), 1'b1, r.image_end));
        end else begin
          // Eight-bit pixels use mask bit1 only.
          pending_pixels.push_back(beat(palette_argb(r.index_byte, r.mask[1]),
                                        1'b1, r.image_end));
        end
      end
      icon_pal_pkg::OP_DIRECT: begin
        p = r.direct;
        pending_pixels.push_back(beat({p[31:24], p[7:0], p[15:8], p[23:16]},
                                      1'b1, r.image_end));
      end
      default: ;  // reserved selector: no pixel
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request builders: fields the op does not use stay random
  // ---------------------------------------------------------------------------

  function automatic pix_req_t random_request();
    pix_req_t r;
    r.op         = 2'($urandom_range(0, 3));
    r.slot       = 8'($urandom);
    r.color      = COLOR_W'($urandom);
    r.index_byte = INDEX_W'($urandom);
    r.mask       = 2'($urandom);
    r.direct     = $urandom;
    r.image_end  = 1'($urandom);
    return r;
  endfunction

  function automatic pix_req_t pal_write_req(logic [7:0] slot, logic [COLOR_W-1:0] color);
    pix_req_t r;
    r       = random_request();
    r.op    = icon_pal_pkg::OP_PAL_WRITE;
    r.slot  = slot;
    r.color = color;
    return r;
  endfunction

  function automatic pix_req_t direct_req(logic [PIXEL_W-1:0] pix, logic last);
    pix_req_t r;
    r           = random_request();
    r.op        = icon_pal_pkg::OP_DIRECT;
    r.direct    = pix;
    r.image_end = last;
    return r;
  endfunction

  function automatic pix_req_t noise_req();
    pix_req_t r;
    r    = random_request();
    r.op = OP_RESERVED;
    return r;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Offer one request after an optional gap and hold it until accepted.
  // Called right after a rising edge; returns at the edge of acceptance.
  task automatic send_item(input pix_req_t r);
    int gap;
    gap = (src_steady || $urandom_range(0, 2) != 0) ? 0 : idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, r.direct, r.mask, r.index_byte, r.color, r.slot};
    s_tuser  <= r.op;
    s_tlast  <= r.image_end;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_request(r);
    if (r.op != OP_RESERVED) items_sent++;
  endtask

  // Fill a palette entry before any pixel reads it.
  task automatic ensure_entry(input logic [INDEX_W-1:0] e);
    if (!pal_valid[e]) send_item(pal_write_req(e, COLOR_W'($urandom)));
  endtask

  task automatic send_indexed(input logic [INDEX_W-1:0] idx, input logic [1:0] mask,
                              input logic last);
    pix_req_t r;
    if (depth_mode == icon_pal_pkg::DEPTH_4BPP) begin
      ensure_entry({4'h0, idx[7:4]});
      ensure_entry({4'h0, idx[3:0]});
    end else begin
      ensure_entry(idx);
    end
    r            = random_request();
    r.op         = icon_pal_pkg::OP_INDEXED;
    r.index_byte = idx;
    r.mask       = mask;
    r.image_end  = last;
    send_item(r);
  endtask

  // Mostly palette pixels, some direct ones.
  task automatic send_random_pixel(input logic last);
    if ($urandom_range(0, 3) != 0) send_indexed(INDEX_W'($urandom), 2'($urandom), last);
    else send_item(direct_req($urandom, last));
  endtask

  // Drop valid, wait for every queued pixel, then let the pipeline settle so
  // a trailing palette write has landed too.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_depth(input logic d);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid  <= 1'b0;
    depth_mode  = d;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver pacing: random stalls, long hold-off on request, steady mode
  // ---------------------------------------------------------------------------

  initial begin : sink_pacing
    forever begin
      @(posedge clk);
      if (sink_stall_left > 0) begin
        m_tready <= 1'b0;
        sink_stall_left--;
      end else if (hold_off_req) begin
        // Long hold-off so the block fills and pushes back on its input.
        hold_off_req    = 1'b0;
        sink_stall_left = HOLD_OFF_CYCLES - 1;
        m_tready       <= 1'b0;
      end else if (!sink_steady && $urandom_range(0, 3) == 0) begin
        sink_stall_left = idle_len() - 1;
        m_tready       <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  function automatic void note_mismatch(string what, logic [PIXEL_W-1:0] want,
                                        logic [PIXEL_W-1:0] got);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("%0t ns: %s mismatch: expected %h, got %h", $time, what, want, got);
  endfunction

  always @(posedge clk) begin : check_results
    argb_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_pixels.size() == 0) begin
        note_mismatch("unexpected pixel", '0, m_tdata);
      end else begin
        want = pending_pixels.pop_front();
        if (m_tdata !== want.argb)      note_mismatch("argb_pixel", want.argb, m_tdata);
        if (m_tlast !== want.run_last)
          note_mismatch("run_last", PIXEL_W'(want.run_last), PIXEL_W'(m_tlast));
        if (m_tuser !== want.frame_last)
          note_mismatch("frame_last", PIXEL_W'(want.frame_last), PIXEL_W'(m_tuser));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset depth is 8 bits: extreme indices, all mask patterns, direct extremes.
  task automatic test_directed_8bpp();
    send_item(pal_write_req(8'h00, 24'h000000));
    send_item(pal_write_req(8'hFF, 24'hFFFFFF));
    send_item(pal_write_req(8'h0F, 24'h123456));
    send_item(pal_write_req(8'hF0, 24'hA5C3E1));
    send_indexed(8'h00, 2'b00, 1'b0);
    send_indexed(8'hFF, 2'b10, 1'b0);   // masked: alpha clear
    send_indexed(8'h0F, 2'b01, 1'b0);   // bit0 alone is ignored at 8 bits
    send_indexed(8'hF0, 2'b11, 1'b1);
    // Rewrite an entry and read it back right away.
    send_item(pal_write_req(8'h00, 24'h00FF00));
    send_indexed(8'h00, 2'b00, 1'b0);
    send_item(direct_req(32'h0000_0000, 1'b0));
    send_item(direct_req(32'hFFFF_FFFF, 1'b0));
    send_item(direct_req(32'h1122_3344, 1'b1));
    // Reserved selector: nothing must come out.
    send_item(noise_req());
  endtask

  // Two pixels per byte: each nibble and mask bit on its own.
  task automatic test_directed_4bpp();
    send_indexed(8'h00, 2'b00, 1'b0);
    send_indexed(8'hFF, 2'b11, 1'b0);
    send_indexed(8'h0F, 2'b10, 1'b0);
    send_indexed(8'hF0, 2'b01, 1'b1);
    send_item(direct_req(32'hA1B2_C3D4, 1'b1));
  endtask

  // Images: palette refresh, then a pixel run closed by image_end, with some
  // mid-run palette rewrites, reserved selectors and stray frame marks.
  task automatic test_random_images(input int n_items);
    int stop_at;
    int run_len;
    int k;
    int pick;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      repeat ($urandom_range(0, 4))
        send_item(pal_write_req(8'($urandom), COLOR_W'($urandom)));
      run_len = $urandom_range(1, 24);
      for (k = 0; k < run_len; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 5) send_item(pal_write_req(8'($urandom), COLOR_W'($urandom)));
        else if (pick < 8) send_item(noise_req());
        else send_random_pixel(k == run_len - 1 || pick < 10);
      end
    end
  endtask

  // Hold the receiver off while the sender keeps offering back to back.
  task automatic test_back_pressure();
    int k;
    src_steady   = 1'b1;
    hold_off_req = 1'b1;
    for (k = 0; k < 40; k++) send_random_pixel(k == 39);
    src_steady   = 1'b0;
  endtask

  // Full rate on both sides.
  task automatic test_steady_stream();
    int k;
    src_steady  = 1'b1;
    sink_steady = 1'b1;
    for (k = 0; k < 100; k++) send_random_pixel(k % 16 == 15);
    src_steady  = 1'b0;
    sink_steady = 1'b0;
  endtask

  initial begin : run_tests
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_directed_8bpp();
    set_depth(icon_pal_pkg::DEPTH_4BPP);
    test_directed_4bpp();
    set_depth(icon_pal_pkg::DEPTH_8BPP);
    test_random_images(240);
    set_depth(icon_pal_pkg::DEPTH_4BPP);
    test_random_images(240);
    test_back_pressure();
    set_depth(icon_pal_pkg::DEPTH_8BPP);
    test_steady_stream();
    set_depth(icon_pal_pkg::DEPTH_4BPP);
    test_random_images(100);
    set_depth(icon_pal_pkg::DEPTH_8BPP);
    test_random_images(60);
    wait_idle();
    if (err_count == 0 && pending_pixels.size() == 0) begin
      $display("tb_icon_palette_to_argb_top passed");
    end else begin
      $display("tb_icon_palette_to_argb_top failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/icon_pal_pkg.sv
rtl/icon_pal_mem.sv
rtl/icon_pal_lane.sv
rtl/icon_pal_merge.sv
rtl/icon_palette_to_argb_top.sv
rtl/icon_pal_checker.sv
test/tb_icon_palette_to_argb_top.sv
